// ===== hw/rtl/kfcv_pkg.sv =====
// ----------------------------------------------------------------------------
// kfcv_pkg
// Shared types and constants of the constant-velocity Kalman filter.
// ----------------------------------------------------------------------------
package kfcv_pkg;

  localparam int unsigned QFrac = 16;
  localparam int unsigned DivSteps = 48;
  localparam logic signed [31:0] I32Max = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] I32Min = 32'sh8000_0000;

  typedef enum logic [2:0] {
    REG_MEAS_NOISE  = 3'd0,
    REG_PN_POS      = 3'd1,
    REG_PN_CROSS    = 3'd2,
    REG_PN_VEL      = 3'd3,
    REG_MOTION_POS  = 3'd4,
    REG_MOTION_VEL  = 3'd5,
    REG_INIT_VAR    = 3'd6,
    REG_UNUSED      = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_S,
    ST_DIV0_GO,
    ST_DIV0_WAIT,
    ST_DIV1_GO,
    ST_DIV1_WAIT,
    ST_M_K0Y,
    ST_M_K1Y,
    ST_M_K0P,
    ST_M_K0C,
    ST_M_K1C,
    ST_EST,
    ST_PRED_A,
    ST_PRED_B,
    ST_PRED_C,
    ST_OUT
  } seq_state_e;

  typedef struct packed {
    logic start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(I32Max)) r = I32Max;
    else if (v < 64'(I32Min)) r = I32Min;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] clampv(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v < 64'sd0) r = 32'sd0;
    else if (v > 64'(I32Max)) r = I32Max;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/kfcv_div.sv =====
// ----------------------------------------------------------------------------
// kfcv_div
// Restoring divider for the gains: sat32((num << 16) / den), truncated.
// ----------------------------------------------------------------------------
module kfcv_div import kfcv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  div_req_t            req_i,
  output logic                done_o,
  output logic signed [31:0]  quot_o
);

  div_state_e state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [47:0] dvd_q, dvd_d;
  logic [47:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] rem_q, rem_d;
  logic        neg_q, neg_d;
  logic        zero_q, zero_d;
  logic [32:0] trial;
  logic [31:0] anum, aden;
  logic signed [49:0] sq;

  assign anum  = req_i.num[31] ? 32'(-req_i.num) : req_i.num;
  assign aden  = req_i.den[31] ? 32'(-req_i.den) : req_i.den;
  assign trial = {rem_q[31:0], dvd_q[47]} - {1'b0, dvs_q};
  assign sq    = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    zero_d  = zero_q;
    unique case (state_q)
      DIV_IDLE, DIV_DONE: begin
        if (req_i.start) begin
          state_d = DIV_RUN;
          cnt_d   = 6'(DivSteps);
          dvd_d   = {anum, 16'd0};
          quo_d   = '0;
          dvs_d   = aden;
          rem_d   = '0;
          neg_d   = req_i.num[31] ^ req_i.den[31];
          zero_d  = (req_i.den == 32'sd0);
        end
      end
      DIV_RUN: begin
        dvd_d = {dvd_q[46:0], 1'b0};
        if (!trial[32]) begin
          rem_d = trial;
          quo_d = {quo_q[46:0], 1'b1};
        end else begin
          rem_d = {rem_q[31:0], dvd_q[47]};
          quo_d = {quo_q[46:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) state_d = DIV_DONE;
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  assign done_o = (state_q == DIV_DONE);
  assign quot_o = zero_q ? 32'sd0 : sat32(64'(sq));

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DIV_RUN && cnt_q == 6'd1) |=> done_o)
    else $error("divider finish missed");
  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DIV_RUN) |-> (cnt_q != 6'd0))
    else $error("divider count underflow");
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DIV_RUN) |-> (rem_q < {1'b0, dvs_q} || dvs_q == 32'd0))
    else $error("divider remainder out of range");

endmodule

// ===== hw/rtl/kalman_filter_const_velocity_1d.sv =====
// Sequence: two gain divisions (start, 48 steps, finish) on a shared divider
// come first, then ten steps, the products on one shared 32x32 multiplier.
// Flow: one request at a time; busy while a request is open, and a result
// still waiting at the output holds the last step until it is taken.
// Reset: position, velocity and covariance zero, variances 1000.0 (Q16.16);
// writing init_variance restarts the filter the same way with that variance.
// ----------------------------------------------------------------------------
// kalman_filter_const_velocity_1d
// Two-state Kalman filter, Q16.16, sequenced over one multiplier and divider.
// ----------------------------------------------------------------------------
module kalman_filter_const_velocity_1d import kfcv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [31:0] measurement_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] est_position_o,
  output logic signed [31:0] est_velocity_o,
  output logic signed [31:0] pred_position_o,
  output logic signed [31:0] pred_velocity_o,
  output logic [30:0]        pred_var_position_o,
  output logic signed [31:0] pred_covariance_o,
  output logic [30:0]        pred_var_velocity_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  seq_state_e state_q, state_d;
  logic signed [31:0] r_q, qp_q, qc_q, qv_q, mp_q, mv_q;
  logic signed [31:0] pos_q, vel_q, p00_q, p01_q, p11_q;
  logic signed [31:0] z_q, y_q, s_q, k0_q, k1_q;
  logic signed [31:0] m0_q, m1_q, m2_q, m3_q, m4_q, m_q;
  logic signed [31:0] ep_q, ev_q, u00_q, u01_q, u11_q;
  logic signed [31:0] res_pp_q, res_pv_q;
  logic               out_valid_q;
  logic               out_load;
  logic signed [31:0] out_ep_q, out_ev_q, out_pp_q, out_pv_q, out_p01_q;
  logic [30:0]        out_p00_q, out_p11_q;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [63:0] pscaled;
  div_req_t           dreq;
  logic               ddone;
  logic signed [31:0] dquot;
  logic               cfg_we;
  reg_idx_e           cidx;

  kfcv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .done_o (ddone),
    .quot_o (dquot)
  );

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign cidx        = reg_idx_e'(cfg_index_i);
  assign stall_o     = (state_q != ST_IDLE);
  assign out_load    = (state_q == ST_OUT) && !(out_valid_q && stall_i);

  always_comb begin
    ma = k0_q;
    mb = y_q;
    unique case (state_q)
      ST_M_K1Y: begin ma = k1_q; mb = y_q;   end
      ST_M_K0P: begin ma = k0_q; mb = p00_q; end
      ST_M_K0C: begin ma = k0_q; mb = p01_q; end
      ST_M_K1C: begin ma = k1_q; mb = p01_q; end
      default:  begin ma = k0_q; mb = y_q;   end
    endcase
  end

  assign prod    = ma * mb;
  assign pscaled = (prod < 64'sd0) ? -((-prod) >>> QFrac) : (prod >>> QFrac);

  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = p00_q;
    dreq.den   = s_q;
    state_d    = state_q;
    unique case (state_q)
      ST_IDLE:      if (valid_i && !stall_o) state_d = ST_S;
      ST_S:         state_d = ST_DIV0_GO;
      ST_DIV0_GO:   begin dreq.start = 1'b1; state_d = ST_DIV0_WAIT; end
      ST_DIV0_WAIT: if (ddone) state_d = ST_DIV1_GO;
      ST_DIV1_GO:   begin
        dreq.start = 1'b1;
        dreq.num   = p01_q;
        state_d    = ST_DIV1_WAIT;
      end
      ST_DIV1_WAIT: if (ddone) state_d = ST_M_K0Y;
      ST_M_K0Y:     state_d = ST_M_K1Y;
      ST_M_K1Y:     state_d = ST_M_K0P;
      ST_M_K0P:     state_d = ST_M_K0C;
      ST_M_K0C:     state_d = ST_M_K1C;
      ST_M_K1C:     state_d = ST_EST;
      ST_EST:       state_d = ST_PRED_A;
      ST_PRED_A:    state_d = ST_PRED_B;
      ST_PRED_B:    state_d = ST_PRED_C;
      ST_PRED_C:    state_d = ST_OUT;
      ST_OUT:       state_d = (out_valid_q && stall_i) ? ST_OUT : ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      r_q  <= 32'sd65536;
      qp_q <= '0;
      qc_q <= '0;
      qv_q <= '0;
      mp_q <= '0;
      mv_q <= '0;
      pos_q <= '0;
      vel_q <= '0;
      p00_q <= 32'sd65536000;
      p01_q <= '0;
      p11_q <= 32'sd65536000;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && !stall_i) out_valid_q <= 1'b0;
      if (cfg_we) begin
        unique case (cidx)
          REG_MEAS_NOISE: r_q  <= {1'b0, cfg_data_i[30:0]};
          REG_PN_POS:     qp_q <= {1'b0, cfg_data_i[30:0]};
          REG_PN_CROSS:   qc_q <= cfg_data_i;
          REG_PN_VEL:     qv_q <= {1'b0, cfg_data_i[30:0]};
          REG_MOTION_POS: mp_q <= cfg_data_i;
          REG_MOTION_VEL: mv_q <= cfg_data_i;
          REG_INIT_VAR: begin
            pos_q <= '0;
            vel_q <= '0;
            p00_q <= {1'b0, cfg_data_i[30:0]};
            p01_q <= '0;
            p11_q <= {1'b0, cfg_data_i[30:0]};
          end
          default: ;
        endcase
      end
      if (state_q == ST_PRED_C) begin
        pos_q <= res_pp_q;
        vel_q <= res_pv_q;
        p00_q <= clampv(64'(u00_q) + 64'(u01_q) + 64'(u01_q) + 64'(u11_q) + 64'(qp_q));
        p01_q <= sat32(64'(u01_q) + 64'(u11_q) + 64'(qc_q));
        p11_q <= clampv(64'(u11_q) + 64'(qv_q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && valid_i && !stall_o) z_q <= measurement_i;
    if (state_q == ST_S) begin
      y_q <= sat32(64'(z_q) - 64'(pos_q));
      s_q <= sat32(64'(p00_q) + 64'(r_q));
    end
    if (state_q == ST_DIV0_WAIT && ddone) k0_q <= dquot;
    if (state_q == ST_DIV1_WAIT && ddone) k1_q <= dquot;
    m_q <= sat32(pscaled);
    unique case (state_q)
      ST_M_K1Y: m0_q <= m_q;
      ST_M_K0P: m1_q <= m_q;
      ST_M_K0C: m2_q <= m_q;
      ST_M_K1C: m3_q <= m_q;
      ST_EST:   m4_q <= m_q;
      default: ;
    endcase
    if (state_q == ST_PRED_A) begin
      ep_q  <= sat32(64'(pos_q) + 64'(m0_q));
      ev_q  <= sat32(64'(vel_q) + 64'(m1_q));
      u00_q <= clampv(64'(p00_q) - 64'(m2_q));
      u01_q <= sat32(64'(p01_q) - 64'(m3_q));
      u11_q <= clampv(64'(p11_q) - 64'(m4_q));
    end
    if (state_q == ST_PRED_B) begin
      res_pp_q <= sat32(64'(ep_q) + 64'(ev_q) + 64'(mp_q));
      res_pv_q <= sat32(64'(ev_q) + 64'(mv_q));
    end
    if (out_load) begin
      out_ep_q  <= ep_q;
      out_ev_q  <= ev_q;
      out_pp_q  <= pos_q;
      out_pv_q  <= vel_q;
      out_p00_q <= p00_q[30:0];
      out_p01_q <= p01_q;
      out_p11_q <= p11_q[30:0];
    end
  end

  assign valid_o             = out_valid_q;
  assign est_position_o      = out_ep_q;
  assign est_velocity_o      = out_ev_q;
  assign pred_position_o     = out_pp_q;
  assign pred_velocity_o     = out_pv_q;
  assign pred_var_position_o = out_p00_q;
  assign pred_covariance_o   = out_p01_q;
  assign pred_var_velocity_o = out_p11_q;

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> stall_o)
    else $error("request taken while busy");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |=> valid_o)
    else $error("result lost");
  a_var: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !p00_q[31] && !p11_q[31])
    else $error("variance negative");

endmodule
